/* src/msp_pkg.sv */
// ----------------------------------------------------------------------------
// msp_pkg
// Shared widths, reset values, register indexes and types of the motor stall
// power limiter.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int CMD_W    = 16;
  localparam int ENC_W    = 32;
  localparam int SPD_W    = 16;
  localparam int DRIVE_W  = 15;
  localparam int SUM_W    = 22;
  localparam int SPDTH_W  = 23;
  localparam int PWRTH_W  = 22;
  localparam int CFG_W    = 23;
  localparam int CFGIDX_W = 2;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 64;

  localparam int WINDOW_DEF = 8;

  localparam logic [SPD_W-1:0] SPEED_CAP = 16'hFFFF;
  localparam int DRIVE_LIMIT = 12000;

  localparam logic [CFGIDX_W-1:0] REG_SPEED_FIRST  = 2'd0;
  localparam logic [CFGIDX_W-1:0] REG_POWER_FIRST  = 2'd1;
  localparam logic [CFGIDX_W-1:0] REG_SPEED_SECOND = 2'd2;
  localparam logic [CFGIDX_W-1:0] REG_POWER_SECOND = 2'd3;

  localparam logic [SPDTH_W-1:0] SPEED_FIRST_RST  = 23'd24;
  localparam logic [PWRTH_W-1:0] POWER_FIRST_RST  = 22'd67200;
  localparam logic [SPDTH_W-1:0] SPEED_SECOND_RST = 23'd3;
  localparam logic [PWRTH_W-1:0] POWER_SECOND_RST = 22'd38400;

  typedef struct packed {
    logic [SPDTH_W-1:0] speed_first;
    logic [PWRTH_W-1:0] power_first;
    logic [SPDTH_W-1:0] speed_second;
    logic [PWRTH_W-1:0] power_second;
  } cfg_t;

endpackage

/* src/msp_measure.sv */
// ----------------------------------------------------------------------------
// msp_measure
// Speed and absolute power of one item, with the previous encoder count.
// ----------------------------------------------------------------------------
module msp_measure (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [msp_pkg::CMD_W-1:0]    command_power,
  input  logic signed [msp_pkg::ENC_W-1:0]    encoder_count,
  output logic        [msp_pkg::SPD_W-1:0]    speed,
  output logic        [msp_pkg::CMD_W-1:0]    power
);
  import msp_pkg::*;

  logic signed [ENC_W-1:0] last_encoder;
  logic signed [ENC_W:0]   diff;
  logic        [ENC_W:0]   mag;
  logic signed [CMD_W:0]   cmd_ext;
  logic signed [CMD_W:0]   cmd_abs;

  always_comb begin
    diff    = {encoder_count[ENC_W-1], encoder_count} - {last_encoder[ENC_W-1], last_encoder};
    mag     = diff[ENC_W] ? -diff : diff;
    speed   = (mag[ENC_W:SPD_W] != '0) ? SPEED_CAP : mag[SPD_W-1:0];
    cmd_ext = {command_power[CMD_W-1], command_power};
    cmd_abs = cmd_ext[CMD_W] ? -cmd_ext : cmd_ext;
    power   = cmd_abs[CMD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_encoder <= '0;
    end else if (load) begin
      last_encoder <= encoder_count;
    end
  end

endmodule

/* src/msp_window.sv */
// ----------------------------------------------------------------------------
// msp_window
// Sliding windows of speeds and powers as shift lines with running sums.
// ----------------------------------------------------------------------------
module msp_window #(
  parameter int WINDOW = msp_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [msp_pkg::SPD_W-1:0]    speed,
  input  logic [msp_pkg::CMD_W-1:0]    power,
  output logic [msp_pkg::SUM_W-1:0]    speed_sum_next,
  output logic [msp_pkg::SUM_W-1:0]    power_sum_next
);
  import msp_pkg::*;

  logic [SPD_W-1:0] speed_history [WINDOW];
  logic [CMD_W-1:0] power_history [WINDOW];
  logic [SUM_W-1:0] speed_sum;
  logic [SUM_W-1:0] power_sum;

  always_comb begin
    speed_sum_next = speed_sum - SUM_W'(speed_history[WINDOW-1]) + SUM_W'(speed);
    power_sum_next = power_sum - SUM_W'(power_history[WINDOW-1]) + SUM_W'(power);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_sum <= '0;
      power_sum <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        speed_history[i] <= '0;
        power_history[i] <= '0;
      end
    end else if (shift) begin
      speed_sum        <= speed_sum_next;
      power_sum        <= power_sum_next;
      speed_history[0] <= speed;
      power_history[0] <= power;
      for (int i = 1; i < WINDOW; i++) begin
        speed_history[i] <= speed_history[i-1];
        power_history[i] <= power_history[i-1];
      end
    end
  end

endmodule

/* src/msp_clamp.sv */
// ----------------------------------------------------------------------------
// msp_clamp
// Two stall stages and the final drive limit applied to the command.
// ----------------------------------------------------------------------------
module msp_clamp (
  input  logic signed [msp_pkg::CMD_W-1:0]   command_power,
  input  logic        [msp_pkg::SUM_W-1:0]   speed_sum,
  input  logic        [msp_pkg::SUM_W-1:0]   power_sum,
  input  msp_pkg::cfg_t                      cfg,
  output logic signed [msp_pkg::DRIVE_W-1:0] drive_power
);
  import msp_pkg::*;

  localparam int V_W = PWRTH_W + 2;

  function automatic logic signed [V_W-1:0] clamp_sym(
    input logic signed [V_W-1:0] v,
    input logic        [PWRTH_W-1:0] lim
  );
    logic signed [V_W-1:0] pos;
    logic signed [V_W-1:0] neg;
    pos = $signed({2'b00, lim});
    neg = -pos;
    if (v > pos) begin
      clamp_sym = pos;
    end else if (v < neg) begin
      clamp_sym = neg;
    end else begin
      clamp_sym = v;
    end
  endfunction

  logic signed [V_W-1:0] v0;
  logic signed [V_W-1:0] v1;
  logic signed [V_W-1:0] v2;
  logic signed [V_W-1:0] v3;
  logic                  first_on;
  logic                  second_on;

  always_comb begin
    v0        = V_W'(command_power);
    first_on  = ({1'b0, speed_sum} < cfg.speed_first) && (power_sum > cfg.power_first);
    second_on = ({1'b0, speed_sum} < cfg.speed_second) && (power_sum > cfg.power_second);
    v1        = first_on ? clamp_sym(v0, cfg.power_first) : v0;
    v2        = second_on ? clamp_sym(v1, cfg.power_second) : v1;
    v3        = clamp_sym(v2, PWRTH_W'(DRIVE_LIMIT));
    drive_power = v3[DRIVE_W-1:0];
  end

endmodule

/* src/motor_stall_power_limiter.sv */
// ----------------------------------------------------------------------------
// motor_stall_power_limiter
// Limits motor power when the windowed speed is low and power is high.
// An accepted item is held in the input register and moves into the output
// register once that register is empty or being read.
// Throughput: one item per cycle while the output is not stalled; the window sums update once per item.
// An input register and an output register part the two stream sides.
// Reset clears the windows, sums and encoder history and loads the default
// thresholds.
// ----------------------------------------------------------------------------
module motor_stall_power_limiter #(
  parameter int WINDOW = msp_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] command_power, [47:16] encoder_count
  input  logic [msp_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [14:0] drive_power, [36:15] speed_total, [58:37] power_total, rest zero
  output logic [msp_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                              cfg_wen,
  input  logic [msp_pkg::CFGIDX_W-1:0]      cfg_index,
  input  logic [msp_pkg::CFG_W-1:0]         cfg_data
);
  import msp_pkg::*;

  cfg_t cfg;

  logic                     in_full;
  logic signed [CMD_W-1:0]  in_cmd;
  logic        [SPD_W-1:0]  in_speed;
  logic        [CMD_W-1:0]  in_power;
  logic                     accept;
  logic                     advance;

  logic        [SPD_W-1:0]  speed;
  logic        [CMD_W-1:0]  power;
  logic        [SUM_W-1:0]  speed_sum_next;
  logic        [SUM_W-1:0]  power_sum_next;
  logic signed [DRIVE_W-1:0] drive_next;

  logic signed [DRIVE_W-1:0] drive_power;
  logic        [SUM_W-1:0]  speed_total;
  logic        [SUM_W-1:0]  power_total;

  assign advance       = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {(OUT_W - DRIVE_W - 2*SUM_W)'(0), power_total, speed_total,
                          drive_power};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_first  <= SPEED_FIRST_RST;
      cfg.power_first  <= POWER_FIRST_RST;
      cfg.speed_second <= SPEED_SECOND_RST;
      cfg.power_second <= POWER_SECOND_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SPEED_FIRST:  cfg.speed_first  <= cfg_data;
        REG_POWER_FIRST:  cfg.power_first  <= cfg_data[PWRTH_W-1:0];
        REG_SPEED_SECOND: cfg.speed_second <= cfg_data;
        REG_POWER_SECOND: cfg.power_second <= cfg_data[PWRTH_W-1:0];
        default: ;
      endcase
    end
  end

  msp_measure u_measure (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .command_power (s_axis_tdata[CMD_W-1:0]),
    .encoder_count (s_axis_tdata[CMD_W+ENC_W-1:CMD_W]),
    .speed         (speed),
    .power         (power)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd   <= s_axis_tdata[CMD_W-1:0];
      in_speed <= speed;
      in_power <= power;
    end
  end

  msp_window #(.WINDOW(WINDOW)) u_window (
    .clk            (clk),
    .rst            (rst),
    .shift          (advance),
    .speed          (in_speed),
    .power          (in_power),
    .speed_sum_next (speed_sum_next),
    .power_sum_next (power_sum_next)
  );

  msp_clamp u_clamp (
    .command_power (in_cmd),
    .speed_sum     (speed_sum_next),
    .power_sum     (power_sum_next),
    .cfg           (cfg),
    .drive_power   (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_power <= drive_next;
      speed_total <= speed_sum_next;
      power_total <= power_sum_next;
    end
  end

  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (drive_power <= 15'sd12000) && (drive_power >= -15'sd12000))
    else $error("drive_power outside the drive limit");

  a_speed_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (speed_total <= SUM_W'(WINDOW * 65535)))
    else $error("speed_total exceeds the window maximum");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> s_axis_tready)
    else $error("input not ready while the input register is empty");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> in_full)
    else $error("accepted item not held in the input register");

endmodule

/* dv/stall_limit_monitor.sv */
// ----------------------------------------------------------------------------
// stall_limit_monitor
// Watches the input, output and register ports of the stall power limiter.
// It keeps its own copy of the speed and power windows and thresholds, works
// out the limited drive power and both window sums for every accepted item,
// and compares each delivered result with the oldest expected one.
// ----------------------------------------------------------------------------
module stall_limit_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [msp_pkg::IN_W-1:0]     s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [msp_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         cfg_wen,
  input  logic [msp_pkg::CFGIDX_W-1:0] cfg_index,
  input  logic [msp_pkg::CFG_W-1:0]    cfg_data,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import msp_pkg::*;

  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic [SUM_W-1:0]   speed_sum;
    logic [SUM_W-1:0]   power_sum;
  } drive_result_t;

  drive_result_t    limited_q[$];
  logic [SPD_W-1:0] speed_win[WINDOW_DEF];
  logic [SPD_W-1:0] power_win[WINDOW_DEF];
  logic [ENC_W-1:0] prev_count;
  logic [SUM_W-1:0] speed_acc;
  logic [SUM_W-1:0] power_acc;
  int unsigned      slot;
  logic [SPDTH_W-1:0] speed_lim1;
  logic [PWRTH_W-1:0] power_lim1;
  logic [SPDTH_W-1:0] speed_lim2;
  logic [PWRTH_W-1:0] power_lim2;
  int               mismatches = 0;

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  function automatic drive_result_t limit_tick(logic [CMD_W-1:0] cmd_bits,
                                               logic [ENC_W-1:0] enc_bits);
    longint        cmd;
    longint        diff;
    longint        mag;
    longint        v;
    logic [SPD_W-1:0] spd;
    logic [SPD_W-1:0] pwr;
    drive_result_t r;
    cmd  = longint'(signed'(cmd_bits));
    diff = longint'(signed'(enc_bits)) - longint'(signed'(prev_count));
    mag  = (diff < 0) ? -diff : diff;
    spd  = (mag > 65535) ? SPEED_CAP : SPD_W'(mag);
    pwr  = SPD_W'((cmd < 0) ? -cmd : cmd);
    speed_acc = speed_acc - SUM_W'(speed_win[slot]) + SUM_W'(spd);
    power_acc = power_acc - SUM_W'(power_win[slot]) + SUM_W'(pwr);
    speed_win[slot] = spd;
    power_win[slot] = pwr;
    slot = (slot + 1) % WINDOW_DEF;
    prev_count = enc_bits;
    v = cmd;
    if (speed_acc < speed_lim1 && power_acc > power_lim1) begin
      v = clamp_mag(v, longint'(power_lim1));
    end
    if (speed_acc < speed_lim2 && power_acc > power_lim2) begin
      v = clamp_mag(v, longint'(power_lim2));
    end
    v = clamp_mag(v, DRIVE_LIMIT);
    r.drive     = DRIVE_W'(v);
    r.speed_sum = speed_acc;
    r.power_sum = power_acc;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    drive_result_t want;
    if (rst) begin
      limited_q.delete();
      for (int i = 0; i < WINDOW_DEF; i++) begin
        speed_win[i] = '0;
        power_win[i] = '0;
      end
      prev_count = '0;
      speed_acc  = '0;
      power_acc  = '0;
      slot       = 0;
      speed_lim1 = SPEED_FIRST_RST;
      power_lim1 = POWER_FIRST_RST;
      speed_lim2 = SPEED_SECOND_RST;
      power_lim2 = POWER_SECOND_RST;
    end else begin
      if (m_tvalid && m_tready) begin
        if (limited_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual %h", $time, m_tdata);
        end else begin
          want = limited_q.pop_front();
          if (m_tdata[DRIVE_W-1:0] !== want.drive) begin
            mismatches++;
            $display("%0t: drive_power expected %0d actual %0d", $time,
                     $signed(want.drive), $signed(m_tdata[DRIVE_W-1:0]));
          end
          if (m_tdata[DRIVE_W +: SUM_W] !== want.speed_sum) begin
            mismatches++;
            $display("%0t: speed_total expected %0d actual %0d", $time,
                     want.speed_sum, m_tdata[DRIVE_W +: SUM_W]);
          end
          if (m_tdata[DRIVE_W+SUM_W +: SUM_W] !== want.power_sum) begin
            mismatches++;
            $display("%0t: power_total expected %0d actual %0d", $time,
                     want.power_sum, m_tdata[DRIVE_W+SUM_W +: SUM_W]);
          end
          if (m_tdata[OUT_W-1:DRIVE_W+2*SUM_W] !== '0) begin
            mismatches++;
            $display("%0t: padding expected 0 actual %h", $time,
                     m_tdata[OUT_W-1:DRIVE_W+2*SUM_W]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        limited_q.push_back(limit_tick(s_tdata[CMD_W-1:0],
                                       s_tdata[CMD_W +: ENC_W]));
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_SPEED_FIRST:  speed_lim1 = cfg_data[SPDTH_W-1:0];
          REG_POWER_FIRST:  power_lim1 = cfg_data[PWRTH_W-1:0];
          REG_SPEED_SECOND: speed_lim2 = cfg_data[SPDTH_W-1:0];
          REG_POWER_SECOND: power_lim2 = cfg_data[PWRTH_W-1:0];
          default: ;
        endcase
      end
    end
    pending    <= limited_q.size();
    fail_count <= mismatches;
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the motor stall power limiter.
// A directed opening covers encoder and command extremes and stalled windows,
// then phases of random ticks run under several threshold settings. About half the
// ticks form stalled or slowly moving runs so that both stall stages engage,
// the rest are free-running moves and fully random noise. Both stream sides
// idle in random bursts; the last phase runs without idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msp_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_wen   = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index = REG_SPEED_FIRST;
  logic [CFG_W-1:0]    cfg_data  = '0;
  logic                idle_on   = 1'b1;
  int                  fail_count;
  int                  pending;
  int                  ready_hold = 0;
  int                  sent = 0;
  logic [ENC_W-1:0]    enc_pos = '0;

  motor_stall_power_limiter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  stall_limit_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      m_tready   <= 1'b0;
      ready_hold <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ENC_W-1:0] enc);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {enc, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] speed1, input logic [CFG_W-1:0] power1,
                                input logic [CFG_W-1:0] speed2, input logic [CFG_W-1:0] power2);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_SPEED_FIRST;
    cfg_data  <= speed1;
    @(posedge clk);
    cfg_index <= REG_POWER_FIRST;
    cfg_data  <= power1;
    @(posedge clk);
    cfg_index <= REG_SPEED_SECOND;
    cfg_data  <= speed2;
    @(posedge clk);
    cfg_index <= REG_POWER_SECOND;
    cfg_data  <= power2;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    int               target;
    int               mode;
    int               len;
    int               waits;
    logic [ENC_W-1:0] step;
    logic [CMD_W-1:0] cmd;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Opening ticks: the first is measured against a zero encoder history,
    // then jumps across the full signed range with the most negative command.
    push_item(16'h7FFF, 32'h7FFF_FFFF);
    push_item(16'h8000, 32'h8000_0000);
    push_item(16'h0000, 32'h8000_0000);
    push_item(16'hFFFF, 32'h8000_0001);
    push_item(16'd12001, 32'h8000_0004);
    push_item(-16'sd12001, 32'h8000_0002);
    for (int i = 0; i < 8; i++) begin
      push_item((i % 2) ? 16'h8000 : 16'h7FFF, 32'h8000_0002);
    end
    drain();
    set_thresholds(23'd24, 23'd1000, 23'd3, 23'd500);
    for (int i = 0; i < 9; i++) begin
      push_item((i % 3 == 0) ? 16'd700 : ((i % 3 == 1) ? -16'sd800 : 16'h8000),
                32'h8000_0002 + i[31:0] % 2);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_thresholds(SPEED_FIRST_RST, CFG_W'(POWER_FIRST_RST),
                          SPEED_SECOND_RST, CFG_W'(POWER_SECOND_RST));
        1: set_thresholds(23'd0, 23'd0, 23'd0, 23'd0);
        2: set_thresholds(23'h7FFFFF, 23'd0, 23'h7FFFFF, 23'd0);
        3: set_thresholds(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        4: set_thresholds(23'd100, 23'd20000, 23'd10, 23'd12000);
        default: set_thresholds(CFG_W'($urandom_range(0, 400)),
                                CFG_W'($urandom_range(0, 150000)),
                                CFG_W'($urandom_range(0, 40)),
                                CFG_W'($urandom_range(0, 100000)));
      endcase
      idle_on <= (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        mode = $urandom_range(0, 9);
        len  = $urandom_range(4, 24);
        for (int k = 0; k < len; k++) begin
          if (mode >= 8) begin
            enc_pos = $urandom;
            cmd     = CMD_W'($urandom);
          end else begin
            // Stalled runs creep by a count or two; moving runs travel farther.
            step = (mode >= 5) ? $urandom_range(0, 3000) : $urandom_range(0, 2);
            enc_pos = $urandom_range(0, 1) ? enc_pos + step : enc_pos - step;
            cmd = (mode >= 5) ? CMD_W'($urandom) : CMD_W'($urandom_range(4000, 32767));
            if ($urandom_range(0, 1)) begin
              cmd = -cmd;
            end
            if ($urandom_range(0, 15) == 0) begin
              cmd = 16'h8000;
            end
          end
          push_item(cmd, enc_pos);
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    waits = 0;
    while (pending != 0 && waits < 20000) begin
      @(posedge clk);
      waits++;
    end
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/msp_pkg.sv
src/msp_measure.sv
src/msp_window.sv
src/msp_clamp.sv
src/motor_stall_power_limiter.sv
dv/stall_limit_monitor.sv
dv/testbench.sv
